// ===== rtl/core/qvr_pkg.sv =====
// Shared types and constants for the quaternion vector rotation pipeline.
`timescale 1ns / 1ps

package qvr_pkg;

	// Number of register stages, the last being the output register
	localparam int NSTAGE = 6;

	// Operand and intermediate widths
	localparam int VW  = 16;            // vector and quaternion components
	localparam int RW  = VW + 1;        // signed quaternion vector part, holds +32768
	localparam int PW  = RW + VW;       // r*v and w*v products
	localparam int TW  = PW;            // t = r x v + w*v, exact
	localparam int QW  = RW + TW;       // r*t products
	localparam int CW  = QW - 1;        // c = r x t, exact
	localparam int SH  = 29;            // 2*c / 2^30
	localparam int DW  = CW - SH;       // rounded correction term
	localparam int OW  = DW + 1;        // v + correction before clipping

	typedef logic signed [VW-1:0] v16_t;
	typedef logic signed [RW-1:0] r17_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [TW-1:0] t_t;
	typedef logic signed [QW-1:0] qprod_t;
	typedef logic signed [CW-1:0] c_t;
	typedef logic signed [DW-1:0] d_t;
	typedef logic signed [OW-1:0] o_t;

	// Rounding offset: half of 2^SH, ties go toward +infinity
	localparam c_t RND_HALF = c_t'(1) <<< (SH - 1);

	// Clip bounds of the output format
	localparam o_t OUT_MAX = o_t'(16'sh7fff);
	localparam o_t OUT_MIN = o_t'(-17'sd32768);

	// Pipeline control between the valid chain and the datapath
	typedef struct packed {
		logic [NSTAGE-1:0] en;    // stage k loads this cycle
		logic [NSTAGE-1:0] vld;   // stage k holds a live transaction
	} pipe_ctl_t;

endpackage

// ===== rtl/core/qvr_pipe_ctrl.sv =====
// Valid chain and per-stage load enables with bubble collapse.
`timescale 1ns / 1ps

module qvr_pipe_ctrl
	import qvr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output pipe_ctl_t ctl
);

	logic [NSTAGE-1:0] vld_q;
	logic [NSTAGE-1:0] en;

	// A stage loads when it is empty or its content moves on
	always_comb begin
		en[NSTAGE-1] = !vld_q[NSTAGE-1] || out_ready;
		for (int k = NSTAGE - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NSTAGE; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[NSTAGE-1];
	assign ctl.en    = en;
	assign ctl.vld   = vld_q;

endmodule

// ===== rtl/core/qvr_rot_core.sv =====
// Stages 1 to 5: sign, r x v + w*v, r x t and rounding offset.
`timescale 1ns / 1ps

module qvr_rot_core
	import qvr_pkg::*;
(
	input  logic      clk,
	input  pipe_ctl_t ctl,
	input  logic      sign_conv,
	input  v16_t      q_w,
	input  v16_t      q_x,
	input  v16_t      q_y,
	input  v16_t      q_z,
	input  v16_t      in_x,
	input  v16_t      in_y,
	input  v16_t      in_z,
	output c_t        cr_s5 [3],
	output v16_t      v_s5 [3]
);

	v16_t   q_in [3];
	v16_t   v_in [3];

	v16_t   w_s1;
	r17_t   r_s1 [3];
	v16_t   v_s1 [3];

	prod_t  a_s2 [3];
	prod_t  b_s2 [3];
	prod_t  wv_s2 [3];
	r17_t   r_s2 [3];
	v16_t   v_s2 [3];

	t_t     t_s3 [3];
	r17_t   r_s3 [3];
	v16_t   v_s3 [3];

	qprod_t e_s4 [3];
	qprod_t f_s4 [3];
	v16_t   v_s4 [3];

	assign q_in[0] = q_x;
	assign q_in[1] = q_y;
	assign q_in[2] = q_z;
	assign v_in[0] = in_x;
	assign v_in[1] = in_y;
	assign v_in[2] = in_z;

	for (genvar j = 0; j < 3; j++) begin : g_lane
		localparam int J1 = (j + 1) % 3;
		localparam int J2 = (j + 2) % 3;

		// Stage 1: apply epsilon to the quaternion vector part
		always_ff @(posedge clk) begin
			if (ctl.en[0]) begin
				r_s1[j] <= sign_conv ? -r17_t'(q_in[j]) : r17_t'(q_in[j]);
				v_s1[j] <= v_in[j];
			end
		end

		// Stage 2: products of r x v and w*v
		always_ff @(posedge clk) begin
			if (ctl.en[1]) begin
				a_s2[j]  <= prod_t'(r_s1[J1]) * prod_t'(v_s1[J2]);
				b_s2[j]  <= prod_t'(r_s1[J2]) * prod_t'(v_s1[J1]);
				wv_s2[j] <= prod_t'(w_s1) * prod_t'(v_s1[j]);
				r_s2[j]  <= r_s1[j];
				v_s2[j]  <= v_s1[j];
			end
		end

		// Stage 3: t = r x v + w*v, exact in TW bits
		always_ff @(posedge clk) begin
			if (ctl.en[2]) begin
				t_s3[j] <= t_t'(a_s2[j]) - t_t'(b_s2[j]) + t_t'(wv_s2[j]);
				r_s3[j] <= r_s2[j];
				v_s3[j] <= v_s2[j];
			end
		end

		// Stage 4: products of r x t
		always_ff @(posedge clk) begin
			if (ctl.en[3]) begin
				e_s4[j] <= qprod_t'(r_s3[J1]) * qprod_t'(t_s3[J2]);
				f_s4[j] <= qprod_t'(r_s3[J2]) * qprod_t'(t_s3[J1]);
				v_s4[j] <= v_s3[j];
			end
		end

		// Stage 5: c = r x t plus rounding half
		always_ff @(posedge clk) begin
			if (ctl.en[4]) begin
				cr_s5[j] <= c_t'(e_s4[j]) - c_t'(f_s4[j]) + RND_HALF;
				v_s5[j]  <= v_s4[j];
			end
		end
	end

	// Scalar part rides along stage 1
	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			w_s1 <= q_w;
		end
	end

endmodule

// ===== rtl/core/qvr_round_sat.sv =====
// Stage 6: scale by 2, add to v, clip to 16 bits and hold the result.
`timescale 1ns / 1ps

module qvr_round_sat
	import qvr_pkg::*;
(
	input  logic      clk,
	input  pipe_ctl_t ctl,
	input  c_t        cr_s5 [3],
	input  v16_t      v_s5 [3],
	output v16_t      out_x,
	output v16_t      out_y,
	output v16_t      out_z,
	output logic      saturated
);

	v16_t       res [3];
	logic [2:0] clip;
	v16_t       res_s6 [3];
	logic       sat_s6;

	for (genvar j = 0; j < 3; j++) begin : g_lane
		d_t d;
		o_t o;

		// Floor shift of the offset term, then clip
		always_comb begin
			d = d_t'(cr_s5[j] >>> SH);
			o = o_t'(v_s5[j]) + o_t'(d);
			if (o > OUT_MAX) begin
				res[j]  = v16_t'(OUT_MAX);
				clip[j] = 1'b1;
			end else if (o < OUT_MIN) begin
				res[j]  = v16_t'(OUT_MIN);
				clip[j] = 1'b1;
			end else begin
				res[j]  = v16_t'(o);
				clip[j] = 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (ctl.en[NSTAGE-1]) begin
			res_s6 <= res;
			sat_s6 <= |clip;
		end
	end

	assign out_x     = res_s6[0];
	assign out_y     = res_s6[1];
	assign out_z     = res_s6[2];
	assign saturated = sat_s6;

endmodule

// ===== rtl/core/quaternion_vector_rotate.sv =====
// Top level: rotates a 3-vector by a quaternion, v + 2*(r x (r x v + w*v)).
//
// Input channel (in_valid/in_ready) carries one quaternion q_w..q_z in
// signed Q1.15 and one vector in_x..in_z per transaction. Output channel
// (out_valid/out_ready) returns the rotated vector out_x..out_z in the
// input's format plus a saturated flag, one result per input transaction,
// in order.
// cfg_we/cfg_data write the sign convention: 0 uses the quaternion vector
// part as given, 1 negates it. Write it only while the pipeline is empty.
// Each transaction passes through the six register stages in order, the last
// being the output register (two of them hold the 17x16 and 17x33 multiplier
// banks); throughput is one transaction per cycle while the receiver does not stall.
// Reset clears all valid bits and the sign convention; no result is
// pending after reset.
// When the receiver stalls, the output register holds its result and
// earlier stages keep filling any empty slots, so inputs are still taken
// until the pipeline is full; nothing is dropped or repeated.
`timescale 1ns / 1ps

module quaternion_vector_rotate
	import qvr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  v16_t q_w,
	input  v16_t q_x,
	input  v16_t q_y,
	input  v16_t q_z,
	input  v16_t in_x,
	input  v16_t in_y,
	input  v16_t in_z,
	output logic out_valid,
	input  logic out_ready,
	output v16_t out_x,
	output v16_t out_y,
	output v16_t out_z,
	output logic saturated
);

	logic      sign_q;
	pipe_ctl_t ctl;
	c_t        cr_s5 [3];
	v16_t      v_s5 [3];

	// Sign convention register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sign_q <= 1'b0;
		end else if (cfg_we) begin
			sign_q <= cfg_data;
		end
	end

	qvr_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	qvr_rot_core u_core (
		.clk       (clk),
		.ctl       (ctl),
		.sign_conv (sign_q),
		.q_w       (q_w),
		.q_x       (q_x),
		.q_y       (q_y),
		.q_z       (q_z),
		.in_x      (in_x),
		.in_y      (in_y),
		.in_z      (in_z),
		.cr_s5     (cr_s5),
		.v_s5      (v_s5)
	);

	qvr_round_sat u_out (
		.clk       (clk),
		.ctl       (ctl),
		.cr_s5     (cr_s5),
		.v_s5      (v_s5),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.saturated (saturated)
	);

endmodule
